### rtl/core/fmf_pkg.sv
// ----------------------------------------------------------------------------
// fmf_pkg : shared types and constants of the FIX message framer
// Phase codes, result status codes, the result item and the push bundle
// handed from the framing logic to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fmf_pkg;

  // Width of the parsed body length; larger values abort the frame.
  localparam int LEN_WIDTH = 16;
  localparam int ACC_WIDTH = LEN_WIDTH + 4;
  localparam logic [ACC_WIDTH-1:0] LEN_MAX = ACC_WIDTH'((64'd1 << LEN_WIDTH) - 64'd1);

  // Frame length counter and limit register.
  localparam int CNT_WIDTH = 16;
  localparam logic [CNT_WIDTH-1:0] MAX_LEN_RESET = 16'd4096;

  // Output queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_8   = 8'h38;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_GOT8,
    PH_BEGIN,
    PH_TAG9,
    PH_TAG9EQ,
    PH_LEN,
    PH_BODY,
    PH_T1,
    PH_T0,
    PH_TEQ,
    PH_CK0,
    PH_CK1,
    PH_CK2,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ST_INNER = 2'd0,
    ST_GOOD  = 2'd1,
    ST_ABORT = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    status_t    status;
    logic       last;
  } result_t;

  // Up to two results per input item, written in order r0 then r1.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

### rtl/core/fmf_out_fifo.sv
// ----------------------------------------------------------------------------
// fmf_out_fifo : result queue of the FIX message framer
// Small register queue taking up to two items per cycle and giving one.
// Room is flagged while at least two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module fmf_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fmf_pkg::push_t  push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fmf_pkg::result_t     out_item
);
  import fmf_pkg::*;

  result_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign room      = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + Q_PTR_W'(1)] <= push.r1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fix_message_framer_unit.sv
// ----------------------------------------------------------------------------
// fix_message_framer_unit : FIX frame cutter for a received byte stream
// Hunts for "8=", follows the "9=" length field, counts out the body and
// checks the "10=" trailer, passing every frame byte on with start and
// end-of-frame status.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | dir | moves
//  ---------+-----------------------------------------------+-----+-----------------
//  in       | in_valid, in_ready, in_byte                   | in  | one stream byte
//  out      | out_valid, out_ready, out_byte,               | out | one frame byte
//           | out_frame_start, out_frame_status, out_run_last|     |
//  cfg      | cfg_wr_en, cfg_wr_data                        | in  | max_frame_len
//
//  - One item per cycle sustained while the queue has room: the phase machine
//    and counters update in the cycle the byte is taken, and results land in a
//    4-entry queue, where each item is registered before it leaves.
//  - in_ready is high while the queue has two free entries, since the byte
//    closing "8=" yields two items; an out stall backs up into in_ready.
//  - Synchronous active-low reset: hunting for "8", counters cleared,
//    queue empty, max_frame_len back to 4096.
//  - No clearing pass after reset; ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module fix_message_framer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  // frame bytes out
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_start,
  output logic [1:0]       out_frame_status,
  output logic             out_run_last,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import fmf_pkg::*;

  // state
  phase_t                  phase_r, phase_nxt;
  logic [CNT_WIDTH-1:0]    frame_count_r, frame_count_nxt;
  logic [LEN_WIDTH-1:0]    length_accum_r, length_accum_nxt;
  logic [LEN_WIDTH-1:0]    body_rem_r, body_rem_nxt;
  logic                    digit_seen_r, digit_seen_nxt;
  logic [CNT_WIDTH-1:0]    max_len_r;

  // per-byte decisions
  logic                    in_fire;
  logic                    room;
  status_t                 status_w;
  logic                    open_w;      // byte completes "8="
  logic                    open_abort_w;
  logic [CNT_WIDTH:0]      count_inc_w;
  logic                    is_digit_w;
  logic [ACC_WIDTH-1:0]    acc_w;
  push_t                   push;
  result_t                 head;

  assign in_ready = room;
  assign in_fire  = in_valid && in_ready;

  assign count_inc_w  = {1'b0, frame_count_r} + (CNT_WIDTH+1)'(1);
  assign is_digit_w   = (in_byte >= CH_0) && (in_byte <= CH_9);
  // accum * 10 + digit, wide enough to spot overflow past LEN_MAX
  assign acc_w        = (ACC_WIDTH'(length_accum_r) << 3) + (ACC_WIDTH'(length_accum_r) << 1)
                      + ACC_WIDTH'(in_byte - CH_0);
  assign open_abort_w = ({{(CNT_WIDTH-2){1'b0}}, 2'd2} >= max_len_r);

  // --------------------------------------------------------------------------
  // Next state: phase machine and counters
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt        = phase_r;
    frame_count_nxt  = frame_count_r;
    length_accum_nxt = length_accum_r;
    body_rem_nxt     = body_rem_r;
    digit_seen_nxt   = digit_seen_r;
    status_w         = ST_INNER;
    open_w           = 1'b0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_byte == CH_8) phase_nxt = PH_GOT8;
        end
        PH_GOT8: begin
          if (in_byte == CH_EQ) begin
            open_w          = 1'b1;
            frame_count_nxt = CNT_WIDTH'(2);
            phase_nxt       = PH_BEGIN;
            if (open_abort_w) status_w = ST_ABORT;
          end else if (in_byte != CH_8) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_BEGIN: begin
          if (in_byte == CH_SOH) phase_nxt = PH_TAG9;
        end
        PH_TAG9: begin
          if (in_byte == CH_9) phase_nxt = PH_TAG9EQ;
          else                 status_w  = ST_ABORT;
        end
        PH_TAG9EQ: begin
          if (in_byte == CH_EQ) phase_nxt = PH_LEN;
          else                  status_w  = ST_ABORT;
        end
        PH_LEN: begin
          if (is_digit_w) begin
            if (acc_w > LEN_MAX) begin
              status_w = ST_ABORT;
            end else begin
              length_accum_nxt = acc_w[LEN_WIDTH-1:0];
              digit_seen_nxt   = 1'b1;
            end
          end else if ((in_byte == CH_SOH) && digit_seen_r) begin
            body_rem_nxt = length_accum_r;
            phase_nxt    = (length_accum_r != '0) ? PH_BODY : PH_T1;
          end else begin
            status_w = ST_ABORT;
          end
        end
        PH_BODY: begin
          if (body_rem_r != '0) body_rem_nxt = body_rem_r - LEN_WIDTH'(1);
          if (body_rem_r <= LEN_WIDTH'(1)) phase_nxt = PH_T1;
        end
        PH_T1: begin
          if (in_byte == CH_1) phase_nxt = PH_T0;
          else                 status_w  = ST_ABORT;
        end
        PH_T0: begin
          if (in_byte == CH_0) phase_nxt = PH_TEQ;
          else                 status_w  = ST_ABORT;
        end
        PH_TEQ: begin
          if (in_byte == CH_EQ) phase_nxt = PH_CK0;
          else                  status_w  = ST_ABORT;
        end
        PH_CK0: phase_nxt = PH_CK1;
        PH_CK1: phase_nxt = PH_CK2;
        PH_CK2: phase_nxt = PH_END;
        default: begin
          status_w = (in_byte == CH_SOH) ? ST_GOOD : ST_ABORT;
        end
      endcase

      // Byte counting and the length limit apply inside a frame only.
      if ((phase_r != PH_HUNT) && (phase_r != PH_GOT8)) begin
        frame_count_nxt = count_inc_w[CNT_WIDTH-1:0];
        if ((status_w == ST_INNER) && (count_inc_w >= {1'b0, max_len_r})) begin
          status_w = ST_ABORT;
        end
      end

      if (status_w != ST_INNER) begin
        phase_nxt        = PH_HUNT;
        frame_count_nxt  = '0;
        length_accum_nxt = '0;
        body_rem_nxt     = '0;
        digit_seen_nxt   = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Outputs: items pushed into the result queue
  // --------------------------------------------------------------------------
  always_comb begin
    push.n         = 2'd0;
    push.r0.data   = in_byte;
    push.r0.start  = 1'b0;
    push.r0.status = status_w;
    push.r0.last   = 1'b1;
    push.r1.data   = CH_EQ;
    push.r1.start  = 1'b0;
    push.r1.status = status_w;
    push.r1.last   = 1'b1;

    if (in_fire) begin
      if (open_w) begin
        // held '8' goes out first as the frame start
        push.n         = 2'd2;
        push.r0.data   = CH_8;
        push.r0.start  = 1'b1;
        push.r0.status = ST_INNER;
        push.r0.last   = 1'b0;
      end else if ((phase_r != PH_HUNT) && (phase_r != PH_GOT8)) begin
        push.n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_count_r  <= '0;
      length_accum_r <= '0;
      body_rem_r     <= '0;
      digit_seen_r   <= 1'b0;
      max_len_r      <= MAX_LEN_RESET;
    end else begin
      phase_r        <= phase_nxt;
      frame_count_r  <= frame_count_nxt;
      length_accum_r <= length_accum_nxt;
      body_rem_r     <= body_rem_nxt;
      digit_seen_r   <= digit_seen_nxt;
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
    end
  end

  fmf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (head)
  );

  assign out_byte         = head.data;
  assign out_frame_start  = head.start;
  assign out_frame_status = head.status;
  assign out_run_last     = head.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Nothing leaves while hunting.
  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_HUNT)) |-> (push.n == 2'd0))
    else $error("item pushed while hunting");

  // A pair of items only ever comes from the byte closing "8=".
  a_pair_open: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> ((phase_r == PH_GOT8) && (in_byte == CH_EQ)))
    else $error("two items outside frame opening");

  // Body phase always has bytes still due.
  a_body_due: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_rem_r != '0))
    else $error("body phase with nothing due");

  // Any end of frame sends the machine back to hunting with counters clear.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (status_w != ST_INNER)) |=>
      ((phase_r == PH_HUNT) && (frame_count_r == '0) && !digit_seen_r))
    else $error("frame end did not clear state");

  // The length field cannot be closed without a digit.
  a_len_digit: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_LEN) && in_fire && (phase_nxt != PH_LEN) && (status_w == ST_INNER))
      |-> digit_seen_r)
    else $error("length closed without a digit");

endmodule

`default_nettype wire
